>>> rtl/shrp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sharpen filter with luma histogram.
// No dependencies; imported by the front end, back end, top level and checker.
package shrp_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int PIX_W     = 24;
	localparam int CH_W      = 8;
	localparam int CFG_W     = 11;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int BIN_W     = 21;
	localparam int NUM_BINS  = 5;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	// register index = paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	localparam int BIN_DARK   = 0;
	localparam int BIN_LOW    = 1;
	localparam int BIN_MID    = 2;
	localparam int BIN_HIGH   = 3;
	localparam int BIN_BRIGHT = 4;

	// one job per effective push or productive drain
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             push;
		logic             emit;
		logic             border;
		logic             fend;
		logic             clr;
	} job_ctl_t;

endpackage

>>> rtl/shrp_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, tracks frame position and pending results,
// and issues jobs with line store addresses. Depends on shrp_pkg.
module shrp_front #(
	parameter int MAX_WIDTH  = shrp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = shrp_pkg::DEF_MAX_HEIGHT,
	localparam int AW = $clog2(2 * MAX_WIDTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [shrp_pkg::CFG_W-1:0]  cfg_width,
	input  logic [shrp_pkg::CFG_W-1:0]  cfg_height,
	input  logic                        cfg_clear,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [shrp_pkg::CH_W-1:0]   in_red,
	input  logic [shrp_pkg::CH_W-1:0]   in_green,
	input  logic [shrp_pkg::CH_W-1:0]   in_blue,
	input  logic                        q_full,
	output logic                        job_valid,
	output shrp_pkg::job_ctl_t          job_ctl,
	output logic [AW-1:0]               job_waddr,
	output logic [AW-1:0]               job_raddr_r,
	output logic [AW-1:0]               job_raddr_u
);
	import shrp_pkg::*;

	localparam int D  = 2 * MAX_WIDTH + 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int EW = (WW > CFG_W) ? WW : CFG_W;
	localparam int EH = (HW > CFG_W) ? HW : CFG_W;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
		ptr_inc = (a == AW'(D - 1)) ? '0 : a + 1'b1;
	endfunction

	// (a - b) mod D, with a < D and b < D
	function automatic logic [AW-1:0] ptr_sub(input logic [AW-1:0] a, input logic [AW:0] b);
		logic [AW:0] ax;
		begin
			ax = {1'b0, a};
			if (ax >= b) ptr_sub = AW'(ax - b);
			else ptr_sub = AW'(ax + (AW + 1)'(D) - b);
		end
	endfunction

	logic [WW-1:0] w_eff, w_last;
	logic [HW-1:0] h_eff, h_last;
	logic [EW-1:0] w_ext;
	logic [EH-1:0] h_ext;

	logic [WW-1:0] in_col_q, e_col_q, pend_q;
	logic [HW-1:0] in_row_q, e_row_q;
	logic [AW-1:0] wp_q, ep_q;

	logic accept, full, is_push, do_push, do_drain, push_emit, emit;
	logic border, fend, start;
	logic [AW:0] sub_r, sub_u;

	always_comb begin
		w_ext = EW'(cfg_width);
		h_ext = EH'(cfg_height);
		if (w_ext == '0) w_eff = WW'(1);
		else if (w_ext > EW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(w_ext);
		if (h_ext == '0) h_eff = HW'(1);
		else if (h_ext > EH'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(h_ext);
		w_last = w_eff - WW'(1);
		h_last = h_eff - HW'(1);
	end

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign full      = (in_row_q == h_eff);
	assign is_push   = (func == FUNC_PUSH);
	assign do_push   = accept && is_push && !full;
	assign do_drain  = accept && !is_push && full && (pend_q != '0);
	assign push_emit = do_push && (pend_q == w_eff);
	assign emit      = push_emit || do_drain;
	assign start     = (in_row_q == '0) && (in_col_q == '0);
	assign border    = (e_row_q == '0) || (e_row_q == h_last) ||
	                   (e_col_q == '0) || (e_col_q == w_last);
	assign fend      = (e_row_q == h_last) && (e_col_q == w_last);

	// right neighbor lies w-1 behind the incoming pixel, upper one 2w behind
	assign sub_r = (AW + 1)'(w_last);
	assign sub_u = (AW + 1)'({w_eff, 1'b0});

	always_comb begin
		job_valid          = do_push || do_drain;
		job_ctl.pix        = {in_red, in_green, in_blue};
		job_ctl.push       = do_push;
		job_ctl.emit       = emit;
		job_ctl.border     = border;
		job_ctl.fend       = fend;
		job_ctl.clr        = do_push && start;
		job_waddr          = wp_q;
		job_raddr_r        = do_push ? ptr_sub(wp_q, sub_r) : ptr_inc(ep_q);
		job_raddr_u        = ptr_sub(wp_q, sub_u);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			e_col_q  <= '0;
			e_row_q  <= '0;
			pend_q   <= '0;
			wp_q     <= '0;
			ep_q     <= '0;
		end else if (cfg_clear || (emit && fend)) begin
			in_col_q <= '0;
			in_row_q <= '0;
			e_col_q  <= '0;
			e_row_q  <= '0;
			pend_q   <= '0;
			wp_q     <= '0;
			ep_q     <= '0;
		end else begin
			if (do_push) begin
				wp_q <= ptr_inc(wp_q);
				if (in_col_q == w_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (!push_emit) pend_q <= pend_q + 1'b1;
			end
			if (do_drain) pend_q <= pend_q - 1'b1;
			if (emit) begin
				ep_q <= ptr_inc(ep_q);
				if (e_col_q == w_last) begin
					e_col_q <= '0;
					e_row_q <= e_row_q + 1'b1;
				end else begin
					e_col_q <= e_col_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/shrp_queue.sv
`timescale 1ns / 1ps
// Short job queue between front and back ends.
// Generic data width; no package dependency, its parameters are set by the top level.
module shrp_queue #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output logic [DW-1:0] head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/shrp_back.sv
`timescale 1ns / 1ps
// Back end: line store, cross-kernel sharpen, luma binning and the result register.
// Depends on shrp_pkg.
module shrp_back #(
	parameter int MAX_WIDTH = shrp_pkg::DEF_MAX_WIDTH,
	localparam int AW = $clog2(2 * MAX_WIDTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  shrp_pkg::job_ctl_t          q_ctl,
	input  logic [AW-1:0]               q_waddr,
	input  logic [AW-1:0]               q_raddr_r,
	input  logic [AW-1:0]               q_raddr_u,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [shrp_pkg::CH_W-1:0]   out_red,
	output logic [shrp_pkg::CH_W-1:0]   out_green,
	output logic [shrp_pkg::CH_W-1:0]   out_blue,
	output logic                        frame_end,
	output logic [shrp_pkg::BIN_W-1:0]  bin_dark,
	output logic [shrp_pkg::BIN_W-1:0]  bin_low,
	output logic [shrp_pkg::BIN_W-1:0]  bin_mid,
	output logic [shrp_pkg::BIN_W-1:0]  bin_high,
	output logic [shrp_pkg::BIN_W-1:0]  bin_bright
);
	import shrp_pkg::*;

	localparam int D     = 2 * MAX_WIDTH + 1;
	localparam int LSW   = 22;
	localparam int LUMA_DEN = 10000;
	localparam logic [LSW-1:0] LUMA_R    = LSW'(2126);
	localparam logic [LSW-1:0] LUMA_G    = LSW'(7152);
	localparam logic [LSW-1:0] LUMA_B    = LSW'(722);
	localparam logic [LSW-1:0] LUMA_RND  = LSW'(LUMA_DEN / 2);
	// L <= limit  <=>  scaled sum < (limit + 1) * 10000
	localparam logic [LSW-1:0] THR_DARK  = LSW'(51 * LUMA_DEN);
	localparam logic [LSW-1:0] THR_LOW   = LSW'(102 * LUMA_DEN);
	localparam logic [LSW-1:0] THR_MID   = LSW'(153 * LUMA_DEN);
	localparam logic [LSW-1:0] THR_HIGH  = LSW'(204 * LUMA_DEN);

	function automatic logic [CH_W-1:0] sharpen(
		input logic [CH_W-1:0] c, input logic [CH_W-1:0] l, input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] u, input logic [CH_W-1:0] d);
		logic [CH_W+2:0] pos, neg, diff;
		begin
			pos  = {1'b0, c, 2'b00} + (CH_W + 3)'(c);
			neg  = (CH_W + 3)'(l) + (CH_W + 3)'(r) + (CH_W + 3)'(u) + (CH_W + 3)'(d);
			diff = pos - neg;
			if (pos < neg) sharpen = '0;
			else if (diff > (CH_W + 3)'(255)) sharpen = '1;
			else sharpen = CH_W'(diff);
		end
	endfunction

	logic adv;

	logic [PIX_W-1:0] mem [D];

	logic             v_s1, v_s2, v_s3;
	job_ctl_t         ctl_s1;
	logic [PIX_W-1:0] rd_r_s1, rd_u_s1;
	logic             byp_s1;

	logic [PIX_W-1:0] prev1_q, prev2_q;
	logic [PIX_W-1:0] right, sharp;

	logic [PIX_W-1:0] rgb_s2, rgb_s3;
	logic             emit_s2, fend_s2, clr_s2;
	logic             emit_s3, fend_s3, clr_s3;
	logic [NUM_BINS-1:0] hit_s3;

	logic [LSW-1:0]      luma_sum;
	logic [NUM_BINS-1:0] hit;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_rgb_q;
	logic             out_fend_q;
	logic [BIN_W-1:0] bins_q [NUM_BINS];

	// whole pipeline holds while a result waits
	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;

	// stage 1: line store write and the two neighbor reads
	always_ff @(posedge clk) begin
		if (q_pop && q_ctl.push) mem[q_waddr] <= q_ctl.pix;
		if (adv) begin
			rd_r_s1 <= mem[q_raddr_r];
			rd_u_s1 <= mem[q_raddr_u];
			ctl_s1  <= q_ctl;
			// one pixel per row: the right neighbor is the pixel written now
			byp_s1  <= q_ctl.push && (q_raddr_r == q_waddr);
		end
	end

	// stage 2: center and left come from the previous right reads
	assign right = byp_s1 ? ctl_s1.pix : rd_r_s1;

	always_comb begin
		sharp[23:16] = sharpen(prev1_q[23:16], prev2_q[23:16], right[23:16],
		                       rd_u_s1[23:16], ctl_s1.pix[23:16]);
		sharp[15:8]  = sharpen(prev1_q[15:8], prev2_q[15:8], right[15:8],
		                       rd_u_s1[15:8], ctl_s1.pix[15:8]);
		sharp[7:0]   = sharpen(prev1_q[7:0], prev2_q[7:0], right[7:0],
		                       rd_u_s1[7:0], ctl_s1.pix[7:0]);
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			prev1_q <= right;
			prev2_q <= prev1_q;
		end
		if (adv) begin
			rgb_s2  <= ctl_s1.border ? prev1_q : sharp;
			emit_s2 <= ctl_s1.emit;
			fend_s2 <= ctl_s1.fend;
			clr_s2  <= ctl_s1.clr;
		end
	end

	// stage 3: luma classification
	always_comb begin
		luma_sum = LUMA_R * LSW'(rgb_s2[23:16]) + LUMA_G * LSW'(rgb_s2[15:8]) +
		           LUMA_B * LSW'(rgb_s2[7:0]) + LUMA_RND;
		hit = '0;
		priority if (luma_sum < THR_DARK) hit[BIN_DARK] = 1'b1;
		else if (luma_sum < THR_LOW) hit[BIN_LOW] = 1'b1;
		else if (luma_sum < THR_MID) hit[BIN_MID] = 1'b1;
		else if (luma_sum < THR_HIGH) hit[BIN_HIGH] = 1'b1;
		else hit[BIN_BRIGHT] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s3  <= rgb_s2;
			hit_s3  <= hit;
			emit_s3 <= emit_s2;
			fend_s3 <= fend_s2;
			clr_s3  <= clr_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && emit_s3) begin
			out_rgb_q  <= rgb_s3;
			out_fend_q <= fend_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_BINS; k++) bins_q[k] <= '0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3 && emit_s3;
			if (v_s3) begin
				for (int k = 0; k < NUM_BINS; k++) begin
					if (clr_s3) bins_q[k] <= '0;
					else if (emit_s3 && hit_s3[k] && (bins_q[k] != '1))
						bins_q[k] <= bins_q[k] + 1'b1;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_rgb_q[23:16];
	assign out_green  = out_rgb_q[15:8];
	assign out_blue   = out_rgb_q[7:0];
	assign frame_end  = out_fend_q;
	assign bin_dark   = bins_q[BIN_DARK];
	assign bin_low    = bins_q[BIN_LOW];
	assign bin_mid    = bins_q[BIN_MID];
	assign bin_high   = bins_q[BIN_HIGH];
	assign bin_bright = bins_q[BIN_BRIGHT];

endmodule

>>> rtl/sharpen_3x3_with_luma_histogram.sv
`timescale 1ns / 1ps
// Top level: APB registers, front end, job queue and back end.
// Depends on shrp_pkg, shrp_front, shrp_queue, shrp_back.
//
// Streaming 3x3 cross-kernel sharpen of an RGB frame in raster order with a
// five-bin luma histogram reported on every result. The block sustains one
// item per clock unless a stall holds it: each item is at most one write and
// two reads of the line store (a 2*MAX_WIDTH+1 entry memory with one write
// and two read ports). A result passes from the job queue through the line
// store reads, sharpen, luma binning and result register; a four-entry job
// queue lets input keep flowing while a result waits. The line store is not
// cleared after reset; its unwritten entries are only ever read for border
// pixels, which copy the center. Register writes (width at 0x0, height at
// 0x4) abandon the current frame and are meant for idle periods only.
module sharpen_3x3_with_luma_histogram #(
	parameter int MAX_WIDTH  = shrp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = shrp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [shrp_pkg::ADDR_W-1:0]  paddr,
	input  logic [shrp_pkg::DATA_W-1:0]  pwdata,
	output logic [shrp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [shrp_pkg::CH_W-1:0]    in_red,
	input  logic [shrp_pkg::CH_W-1:0]    in_green,
	input  logic [shrp_pkg::CH_W-1:0]    in_blue,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [shrp_pkg::CH_W-1:0]    out_red,
	output logic [shrp_pkg::CH_W-1:0]    out_green,
	output logic [shrp_pkg::CH_W-1:0]    out_blue,
	output logic                         frame_end,
	output logic [shrp_pkg::BIN_W-1:0]   bin_dark,
	output logic [shrp_pkg::BIN_W-1:0]   bin_low,
	output logic [shrp_pkg::BIN_W-1:0]   bin_mid,
	output logic [shrp_pkg::BIN_W-1:0]   bin_high,
	output logic [shrp_pkg::BIN_W-1:0]   bin_bright
);
	import shrp_pkg::*;

	localparam int AW = $clog2(2 * MAX_WIDTH + 1);
	localparam int DW = $bits(job_ctl_t) + 3 * AW;

	logic [CFG_W-1:0] width_q, height_q;
	logic             cfg_wr, reg_idx;

	logic             job_valid, q_full, q_valid, q_pop;
	job_ctl_t         job_ctl, q_ctl;
	logic [AW-1:0]    job_waddr, job_raddr_r, job_raddr_u;
	logic [AW-1:0]    q_waddr, q_raddr_r, q_raddr_u;
	logic [DW-1:0]    q_in, q_out;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
		endcase
	end

	shrp_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_width   (width_q),
		.cfg_height  (height_q),
		.cfg_clear   (cfg_wr),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.q_full      (q_full),
		.job_valid   (job_valid),
		.job_ctl     (job_ctl),
		.job_waddr   (job_waddr),
		.job_raddr_r (job_raddr_r),
		.job_raddr_u (job_raddr_u)
	);

	assign q_in = {job_ctl, job_waddr, job_raddr_r, job_raddr_u};

	shrp_queue #(
		.DW    (DW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_out)
	);

	assign {q_ctl, q_waddr, q_raddr_r, q_raddr_u} = q_out;

	shrp_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_ctl      (q_ctl),
		.q_waddr    (q_waddr),
		.q_raddr_r  (q_raddr_r),
		.q_raddr_u  (q_raddr_u),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_end  (frame_end),
		.bin_dark   (bin_dark),
		.bin_low    (bin_low),
		.bin_mid    (bin_mid),
		.bin_high   (bin_high),
		.bin_bright (bin_bright)
	);

endmodule

>>> rtl/shrp_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the top level, bound to it below.
// Depends on shrp_pkg and sharpen_3x3_with_luma_histogram.
module shrp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [shrp_pkg::CH_W-1:0]   out_red,
	input logic [shrp_pkg::CH_W-1:0]   out_green,
	input logic [shrp_pkg::CH_W-1:0]   out_blue,
	input logic                        frame_end,
	input logic [shrp_pkg::BIN_W-1:0]  bin_dark,
	input logic [shrp_pkg::BIN_W-1:0]  bin_low,
	input logic [shrp_pkg::BIN_W-1:0]  bin_mid,
	input logic [shrp_pkg::BIN_W-1:0]  bin_high,
	input logic [shrp_pkg::BIN_W-1:0]  bin_bright
);
	import shrp_pkg::*;

	// a stalled result, bins included, holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) &&
		$stable(out_blue) && $stable(frame_end) && $stable(bin_dark) && $stable(bin_low) &&
		$stable(bin_mid) && $stable(bin_high) && $stable(bin_bright))
		else $error("stalled result changed");

	// the shown bins already count the shown pixel
	a_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((bin_dark | bin_low | bin_mid | bin_high | bin_bright) != '0))
		else $error("result shown with empty histogram");

	// back-to-back results inside a frame never lose counts
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !frame_end) ##1 out_valid |->
		(bin_dark >= $past(bin_dark)) && (bin_low >= $past(bin_low)) &&
		(bin_mid >= $past(bin_mid)) && (bin_high >= $past(bin_high)) &&
		(bin_bright >= $past(bin_bright)))
		else $error("bin count dropped within a frame");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind sharpen_3x3_with_luma_histogram shrp_checker u_shrp_checker (.*);
